// ===== rtl/core/tqdw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tqdw_pkg: shared types and constants for the touch qualifier
// Field widths, screen geometry, operation codes and the structs passed
// between the sequencer, the register file and the mapping unit.
// ----------------------------------------------------------------------------
package tqdw_pkg;

  localparam int RAW_W  = 12;
  localparam int PT_W   = 10;
  localparam int PROD_W = RAW_W + PT_W;
  localparam int CNT_W  = $clog2(PROD_W + 1);
  localparam int TMO_W  = 26;

  localparam int SCREEN_W = 320;
  localparam int SCREEN_H = 240;

  localparam logic [PT_W-1:0] X_TOP = PT_W'(SCREEN_W - 1);
  localparam logic [PT_W-1:0] Y_TOP = PT_W'(SCREEN_H - 1);

  localparam logic [PT_W-1:0] MAX_STEP_PX   = PT_W'(60);
  localparam logic [31:0]     IGNORE_MS     = 32'd300;
  localparam logic [9:0]      MS_PER_SEC    = 10'd1000;
  localparam logic [1:0]      STABLE_NEEDED = 2'd2;
  localparam logic [7:0]      FULL_BRIGHT   = 8'd255;

  typedef enum logic [1:0] {
    MODE_ACTIVE = 2'd0,
    MODE_SAVER  = 2'd1,
    MODE_SLEEP  = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    FUNC_TOUCH  = 2'd0,
    FUNC_IDLE   = 2'd1,
    FUNC_BRIGHT = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    REG_ORIENT    = 3'd0,
    REG_RAW_MIN_X = 3'd1,
    REG_RAW_MAX_X = 3'd2,
    REG_RAW_MIN_Y = 3'd3,
    REG_RAW_MAX_Y = 3'd4,
    REG_PRESS_MIN = 3'd5,
    REG_TIMEOUT   = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [2:0]       orientation;
    logic [RAW_W-1:0] raw_min_x;
    logic [RAW_W-1:0] raw_max_x;
    logic [RAW_W-1:0] raw_min_y;
    logic [RAW_W-1:0] raw_max_y;
    logic [RAW_W-1:0] pressure_min;
    logic [15:0]      timeout_sec;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [RAW_W-1:0] num;
    logic [PT_W-1:0]  factor;
    logic [RAW_W-1:0] den;
  } map_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [PT_W-1:0] quot;
  } map_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/core/tqdw_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tqdw_cfg: configuration register file
// Holds orientation, raw window, pressure floor and idle timeout.
// ----------------------------------------------------------------------------
module tqdw_cfg
  import tqdw_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  output cfg_t             cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.orientation  <= 3'd0;
      cfg_q.raw_min_x    <= '0;
      cfg_q.raw_max_x    <= '1;
      cfg_q.raw_min_y    <= '0;
      cfg_q.raw_max_y    <= '1;
      cfg_q.pressure_min <= '0;
      cfg_q.timeout_sec  <= 16'd30;
    end else if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_ORIENT:    cfg_q.orientation  <= cfg_data_i[2:0];
        REG_RAW_MIN_X: cfg_q.raw_min_x    <= cfg_data_i[RAW_W-1:0];
        REG_RAW_MAX_X: cfg_q.raw_max_x    <= cfg_data_i[RAW_W-1:0];
        REG_RAW_MIN_Y: cfg_q.raw_min_y    <= cfg_data_i[RAW_W-1:0];
        REG_RAW_MAX_Y: cfg_q.raw_max_y    <= cfg_data_i[RAW_W-1:0];
        REG_PRESS_MIN: cfg_q.pressure_min <= cfg_data_i[RAW_W-1:0];
        REG_TIMEOUT:   cfg_q.timeout_sec  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// ===== rtl/core/tqdw_mapper.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tqdw_mapper: shared multiply and serial divide unit
// Computes min(num * factor / den, factor): the product is registered first,
// then one restoring divide step runs per product bit.
// ----------------------------------------------------------------------------
module tqdw_mapper
  import tqdw_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  map_req_t  req_i,
  output map_rsp_t  rsp_o
);

  logic [PROD_W-1:0] prod_q;
  logic [RAW_W-1:0]  rem_q;
  logic [RAW_W-1:0]  den_q;
  logic [PT_W-1:0]   factor_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q;
  logic              done_q;

  logic [RAW_W:0]    rem_sh;
  logic              q_bit;
  logic [RAW_W-1:0]  rem_d;

  // quotient bits shift in at the bottom of prod_q as dividend bits leave the top
  always_comb begin
    rem_sh = {rem_q, prod_q[PROD_W-1]};
    q_bit  = (rem_sh >= {1'b0, den_q});
    rem_d  = q_bit ? RAW_W'(rem_sh - {1'b0, den_q}) : rem_sh[RAW_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
      prod_q   <= '0;
      rem_q    <= '0;
      den_q    <= '0;
      factor_q <= '0;
    end else begin
      if (req_i.start) begin
        prod_q   <= PROD_W'(req_i.num) * PROD_W'(req_i.factor);
        rem_q    <= '0;
        den_q    <= req_i.den;
        factor_q <= req_i.factor;
        cnt_q    <= CNT_W'(PROD_W);
        busy_q   <= 1'b1;
        done_q   <= 1'b0;
      end else if (busy_q) begin
        prod_q <= {prod_q[PROD_W-2:0], q_bit};
        rem_q  <= rem_d;
        cnt_q  <= cnt_q - CNT_W'(1);
        done_q <= (cnt_q == CNT_W'(1));
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end else begin
        done_q <= 1'b0;
      end
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = (prod_q > PROD_W'(factor_q)) ? factor_q : prod_q[PT_W-1:0];

endmodule
`default_nettype wire

// ===== rtl/core/touch_qualifier_display_wake.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// touch_qualifier_display_wake: touch sample qualifier and display power state
// Input channel (in_valid_i / in_stall_o) carries one word per operation:
// a touch poll, an idle-timeout check or a backlight write. Each word gives
// exactly one result word on the output channel (out_valid_o / out_stall_i).
// The configuration channel (cfg_valid_i / cfg_ready_o) writes one register
// per word by index and is always ready.
// A word is taken only while the sequencer is idle; in_stall_o is high
// otherwise. A release, wake, ignored poll or brightness write passes ST_EVAL
// and ST_FINISH, an idle check adds ST_TMO_CMP, and a poll whose point is
// mapped runs ST_MAP_X, ST_WAIT_X, ST_MAP_Y, ST_WAIT_Y and ST_CHECK; each wait
// state holds on the serial divider of the shared mapping unit (22 divide
// steps per axis) and is skipped for an axis whose raw window is collapsed.
// A result waits in the output register while the receiver stalls; the next
// word can be accepted meanwhile, but it is not finished until the pending
// result is taken.
// Reset: display active at full brightness, touch history cleared, and the
// configuration registers at their defaults.
// ----------------------------------------------------------------------------
module touch_qualifier_display_wake
  import tqdw_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // input channel
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [1:0]       func_i,
  input  wire logic [31:0]      now_ms_i,
  input  wire logic             touched_i,
  input  wire logic [RAW_W-1:0] raw_x_i,
  input  wire logic [RAW_W-1:0] raw_y_i,
  input  wire logic [RAW_W-1:0] raw_z_i,
  input  wire logic [7:0]       brightness_value_i,
  // output channel
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic                  pressed_o,
  output logic [PT_W-1:0]       point_x_o,
  output logic [PT_W-1:0]       point_y_o,
  output logic [1:0]            display_mode_o,
  output logic [7:0]            backlight_o,
  output logic                  woke_o,
  output logic                  screensaver_entered_o,
  // configuration channel
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [2:0]       cfg_index_i,
  input  wire logic [15:0]      cfg_data_i
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL,
    ST_TMO_CMP,
    ST_MAP_X,
    ST_WAIT_X,
    ST_MAP_Y,
    ST_WAIT_Y,
    ST_CHECK,
    ST_FINISH
  } state_e;

  cfg_t     cfg;
  map_req_t map_req;
  map_rsp_t map_rsp;

  state_e state_q;

  // captured word
  logic [1:0]       func_q;
  logic [31:0]      now_q;
  logic             touched_q;
  logic [RAW_W-1:0] raw_x_q, raw_y_q, raw_z_q;
  logic [7:0]       bright_q;

  // block state
  mode_e            mode_q;
  logic [7:0]       bl_q;
  logic [31:0]      last_act_q;
  logic [31:0]      ignore_q;
  logic [PT_W-1:0]  prev_x_q, prev_y_q;
  logic             prev_valid_q;
  logic [1:0]       stable_q;
  logic             session_q;

  // working values
  logic [TMO_W-1:0] tmo_q;
  logic [PT_W-1:0]  mx_q, my_q;
  logic             res_pressed_q, res_woke_q, res_saver_q;
  logic [PT_W-1:0]  res_px_q, res_py_q;

  // output register
  logic             out_valid_q;
  logic             out_pressed_q, out_woke_q, out_saver_q;
  logic [PT_W-1:0]  out_px_q, out_py_q;
  logic [1:0]       out_mode_q;
  logic [7:0]       out_bl_q;
  logic             fin_fire;

  tqdw_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  tqdw_mapper u_mapper (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (map_req),
    .rsp_o  (map_rsp)
  );

  // orientation: axis swap, then window selection per screen axis
  logic             swap, inv_x, inv_y;
  logic [RAW_W-1:0] ax, ay, xlo, xhi, ylo, yhi;
  logic             in_range, deg_x, deg_y;
  logic [RAW_W-1:0] num_x, num_y;
  logic [31:0]      gap;
  logic             ignored;
  logic [31:0]      idle_ms;
  logic [PT_W-1:0]  dx, dy;
  logic             jump;

  always_comb begin
    swap  = cfg.orientation[0];
    inv_x = cfg.orientation[1];
    inv_y = cfg.orientation[2];
    ax  = swap ? raw_y_q : raw_x_q;
    ay  = swap ? raw_x_q : raw_y_q;
    xlo = swap ? cfg.raw_min_y : cfg.raw_min_x;
    xhi = swap ? cfg.raw_max_y : cfg.raw_max_x;
    ylo = swap ? cfg.raw_min_x : cfg.raw_min_y;
    yhi = swap ? cfg.raw_max_x : cfg.raw_max_y;
    in_range = (ax >= xlo) && (ax <= xhi) && (ay >= ylo) && (ay <= yhi);
    deg_x = (xhi == xlo);
    deg_y = (yhi == ylo);
    num_x = inv_x ? (xhi - ax) : (ax - xlo);
    num_y = inv_y ? (yhi - ay) : (ay - ylo);
    // wrap-safe window test: ignore while 1 <= ignore_until - now <= 300
    gap     = ignore_q - now_q;
    ignored = (gap != 32'd0) && (gap <= IGNORE_MS);
    idle_ms = now_q - last_act_q;
    dx   = (mx_q > prev_x_q) ? (mx_q - prev_x_q) : (prev_x_q - mx_q);
    dy   = (my_q > prev_y_q) ? (my_q - prev_y_q) : (prev_y_q - my_q);
    jump = prev_valid_q && ((dx > MAX_STEP_PX) || (dy > MAX_STEP_PX));
  end

  always_comb begin
    map_req.start  = ((state_q == ST_MAP_X) && !deg_x) ||
                     ((state_q == ST_MAP_Y) && !deg_y);
    map_req.num    = (state_q == ST_MAP_Y) ? num_y : num_x;
    map_req.factor = (state_q == ST_MAP_Y) ? Y_TOP : X_TOP;
    map_req.den    = (state_q == ST_MAP_Y) ? (yhi - ylo) : (xhi - xlo);
  end

  // result moves to the output register unless a stalled word still sits there
  assign fin_fire = (state_q == ST_FINISH) && !(out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      func_q        <= '0;
      now_q         <= '0;
      touched_q     <= 1'b0;
      raw_x_q       <= '0;
      raw_y_q       <= '0;
      raw_z_q       <= '0;
      bright_q      <= '0;
      mode_q        <= MODE_ACTIVE;
      bl_q          <= FULL_BRIGHT;
      last_act_q    <= '0;
      ignore_q      <= '0;
      prev_x_q      <= '0;
      prev_y_q      <= '0;
      prev_valid_q  <= 1'b0;
      stable_q      <= '0;
      session_q     <= 1'b0;
      tmo_q         <= '0;
      mx_q          <= '0;
      my_q          <= '0;
      res_pressed_q <= 1'b0;
      res_woke_q    <= 1'b0;
      res_saver_q   <= 1'b0;
      res_px_q      <= '0;
      res_py_q      <= '0;
      out_valid_q   <= 1'b0;
      out_pressed_q <= 1'b0;
      out_woke_q    <= 1'b0;
      out_saver_q   <= 1'b0;
      out_px_q      <= '0;
      out_py_q      <= '0;
      out_mode_q    <= MODE_ACTIVE;
      out_bl_q      <= FULL_BRIGHT;
    end else begin
      if (fin_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            func_q    <= func_i;
            now_q     <= now_ms_i;
            touched_q <= touched_i;
            raw_x_q   <= raw_x_i;
            raw_y_q   <= raw_y_i;
            raw_z_q   <= raw_z_i;
            bright_q  <= brightness_value_i;
            state_q   <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          res_pressed_q <= 1'b0;
          res_woke_q    <= 1'b0;
          res_saver_q   <= 1'b0;
          res_px_q      <= '0;
          res_py_q      <= '0;
          state_q       <= ST_FINISH;
          unique case (func_q)
            FUNC_TOUCH: begin
              if (!touched_q) begin
                prev_valid_q <= 1'b0;
                stable_q     <= '0;
                session_q    <= 1'b0;
              end else if (raw_z_q < cfg.pressure_min) begin
                stable_q  <= '0;
                session_q <= 1'b0;
              end else if (mode_q != MODE_ACTIVE) begin
                bl_q       <= FULL_BRIGHT;
                mode_q     <= MODE_ACTIVE;
                ignore_q   <= now_q + IGNORE_MS;
                last_act_q <= now_q;
                res_woke_q <= 1'b1;
              end else if (ignored) begin
                // inside the post-wake window: no change
              end else if (!in_range) begin
                stable_q  <= '0;
                session_q <= 1'b0;
              end else begin
                state_q <= ST_MAP_X;
              end
            end
            FUNC_IDLE: begin
              tmo_q   <= TMO_W'(cfg.timeout_sec) * TMO_W'(MS_PER_SEC);
              state_q <= ST_TMO_CMP;
            end
            FUNC_BRIGHT: begin
              bl_q <= bright_q;
              if (bright_q == 8'd0) begin
                mode_q <= MODE_SLEEP;
              end
            end
            default: ;
          endcase
        end
        ST_TMO_CMP: begin
          if ((mode_q == MODE_ACTIVE) && (cfg.timeout_sec != 16'd0) &&
              (idle_ms >= 32'(tmo_q))) begin
            mode_q      <= MODE_SAVER;
            res_saver_q <= 1'b1;
          end
          state_q <= ST_FINISH;
        end
        ST_MAP_X: begin
          if (deg_x) begin
            mx_q    <= '0;
            state_q <= ST_MAP_Y;
          end else begin
            state_q <= ST_WAIT_X;
          end
        end
        ST_WAIT_X: begin
          if (map_rsp.done) begin
            mx_q    <= map_rsp.quot;
            state_q <= ST_MAP_Y;
          end
        end
        ST_MAP_Y: begin
          if (deg_y) begin
            my_q    <= '0;
            state_q <= ST_CHECK;
          end else begin
            state_q <= ST_WAIT_Y;
          end
        end
        ST_WAIT_Y: begin
          if (map_rsp.done) begin
            my_q    <= map_rsp.quot;
            state_q <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (jump) begin
            stable_q  <= '0;
            session_q <= 1'b0;
          end else begin
            prev_x_q     <= mx_q;
            prev_y_q     <= my_q;
            prev_valid_q <= 1'b1;
            if (stable_q < STABLE_NEEDED) begin
              stable_q <= stable_q + 2'd1;
            end else begin
              if (!session_q) begin
                last_act_q <= now_q;
                session_q  <= 1'b1;
              end
              res_pressed_q <= 1'b1;
              res_px_q      <= mx_q;
              res_py_q      <= my_q;
            end
          end
          state_q <= ST_FINISH;
        end
        ST_FINISH: begin
          if (fin_fire) begin
            out_pressed_q <= res_pressed_q;
            out_px_q      <= res_px_q;
            out_py_q      <= res_py_q;
            out_woke_q    <= res_woke_q;
            out_saver_q   <= res_saver_q;
            out_mode_q    <= mode_q;
            out_bl_q      <= bl_q;
            state_q       <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o            = (state_q != ST_IDLE);
  assign cfg_ready_o           = 1'b1;
  assign out_valid_o           = out_valid_q;
  assign pressed_o             = out_pressed_q;
  assign point_x_o             = out_px_q;
  assign point_y_o             = out_py_q;
  assign display_mode_o        = out_mode_q;
  assign backlight_o           = out_bl_q;
  assign woke_o                = out_woke_q;
  assign screensaver_entered_o = out_saver_q;

`ifndef SYNTHESIS
  // the mapping unit only runs while the sequencer waits on it
  a_map_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !map_rsp.busy)
    else $error("mapper busy while sequencer idle");

  a_map_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    map_rsp.done |-> ((state_q == ST_WAIT_X) || (state_q == ST_WAIT_Y)))
    else $error("mapper finished with no axis pending");

  a_wake_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && woke_o) |->
      ((display_mode_o == MODE_ACTIVE) && (backlight_o == FULL_BRIGHT) && !pressed_o))
    else $error("wake word without full-brightness active display");

  a_saver_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && screensaver_entered_o) |-> (display_mode_o == MODE_SAVER))
    else $error("screensaver flagged but mode differs");
`endif

endmodule
`default_nettype wire

// ===== dv/tb_touch_qualifier_display_wake.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_touch_qualifier_display_wake: self-checking bench for the touch qualifier
// A short table of directed words checks reset, press qualification, wake,
// ignore window, screensaver entry and brightness writes, partly with results
// typed in. Random gestures and noise follow, under eight register settings
// covering every orientation and the window and timeout extremes. The
// rest are checked field by field against a behavioral model of the block,
// with bursty input, patterned output stall and two long receiver hold-offs.
// ----------------------------------------------------------------------------
module tb_touch_qualifier_display_wake;
  import tqdw_pkg::*;

  localparam int          CLK_HALF   = 6;
  localparam int          SETTLE_CYC = 64;     // covers the slowest mapped poll
  localparam int          LONG_HOLD  = 400;
  localparam int          PHASE_WORDS = 80;
  localparam int          LIMIT_NS   = 40_000_000;
  localparam logic [1:0]  FUNC_SPARE = 2'd3;   // undecoded operation

  typedef struct packed {
    logic [1:0]       func;
    logic [31:0]      now_ms;
    logic             touched;
    logic [RAW_W-1:0] raw_x;
    logic [RAW_W-1:0] raw_y;
    logic [RAW_W-1:0] raw_z;
    logic [7:0]       bright;
  } touch_word_t;

  typedef struct packed {
    logic            pressed;
    logic [PT_W-1:0] point_x;
    logic [PT_W-1:0] point_y;
    logic [1:0]      mode;
    logic [7:0]      backlight;
    logic            woke;
    logic            saver;
  } status_word_t;

  typedef struct packed {
    touch_word_t  w;
    logic         known;
    status_word_t s;
  } directed_row_t;

  // DUT ports
  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [1:0]       func_i;
  logic [31:0]      now_ms_i;
  logic             touched_i;
  logic [RAW_W-1:0] raw_x_i;
  logic [RAW_W-1:0] raw_y_i;
  logic [RAW_W-1:0] raw_z_i;
  logic [7:0]       brightness_value_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic             pressed_o;
  logic [PT_W-1:0]  point_x_o;
  logic [PT_W-1:0]  point_y_o;
  logic [1:0]       display_mode_o;
  logic [7:0]       backlight_o;
  logic             woke_o;
  logic             screensaver_entered_o;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [2:0]       cfg_index_i;
  logic [15:0]      cfg_data_i;

  touch_qualifier_display_wake u_top (.*);

  // model state
  cfg_t            cfg_shadow;
  mode_e           disp_mode;
  logic [7:0]      duty;
  logic [31:0]     activity_ms;
  logic [31:0]     quiet_until;
  logic [PT_W-1:0] last_px;
  logic [PT_W-1:0] last_py;
  logic            last_ok;
  logic [1:0]      settle_cnt;
  logic            session_on;

  status_word_t  status_q[$];
  directed_row_t dir_rows[$];
  status_word_t  want;

  int fail_cnt    = 0;
  int n_words     = 0;
  int n_press     = 0;
  int n_wake      = 0;
  int n_saver     = 0;
  int n_settings  = 0;
  int burst_left  = 1;
  int hold_asks   = 0;
  int hold_seen   = 0;
  int hold_left   = 0;
  int gest_left   = 0;
  int gest_x      = 0;
  int gest_y      = 0;
  logic [31:0] now_cursor = 32'h0000_0100;

  always begin
    clk_i = 1'b1;
    #(CLK_HALF);
    clk_i = 1'b0;
    #(CLK_HALF);
  end

  initial begin
    #(LIMIT_NS);
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------- model

  function automatic logic [PT_W-1:0] scale_axis(input logic [RAW_W-1:0] v, lo, hi,
                                                 input logic inv,
                                                 input logic [PT_W-1:0] top);
    int unsigned span;
    int unsigned num;
    int unsigned r;
    if (hi <= lo) return '0;
    span = 32'(hi) - 32'(lo);
    num  = inv ? 32'(hi) - 32'(v) : 32'(v) - 32'(lo);
    r    = (num * 32'(top)) / span;
    return (r > 32'(top)) ? top : PT_W'(r);
  endfunction

  function automatic logic [PT_W-1:0] px_dist(input logic [PT_W-1:0] a, b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic status_word_t predict_status(input touch_word_t w);
    status_word_t     s;
    logic             swap;
    logic [RAW_W-1:0] ax, ay, xlo, xhi, ylo, yhi;
    logic [PT_W-1:0]  mx, my;
    logic [31:0]      gap;
    s    = '0;
    swap = cfg_shadow.orientation[0];
    case (w.func)
      FUNC_TOUCH: begin
        gap = quiet_until - w.now_ms;
        ax  = swap ? w.raw_y : w.raw_x;
        ay  = swap ? w.raw_x : w.raw_y;
        xlo = swap ? cfg_shadow.raw_min_y : cfg_shadow.raw_min_x;
        xhi = swap ? cfg_shadow.raw_max_y : cfg_shadow.raw_max_x;
        ylo = swap ? cfg_shadow.raw_min_x : cfg_shadow.raw_min_y;
        yhi = swap ? cfg_shadow.raw_max_x : cfg_shadow.raw_max_y;
        if (!w.touched) begin
          last_ok    = 1'b0;
          settle_cnt = '0;
          session_on = 1'b0;
        end else if (w.raw_z < cfg_shadow.pressure_min) begin
          settle_cnt = '0;
          session_on = 1'b0;
        end else if (disp_mode != MODE_ACTIVE) begin
          duty        = FULL_BRIGHT;
          disp_mode   = MODE_ACTIVE;
          quiet_until = w.now_ms + IGNORE_MS;
          activity_ms = w.now_ms;
          s.woke      = 1'b1;
        end else if (gap >= 32'd1 && gap <= IGNORE_MS) begin
          // post-wake window, modulo 2^32 so it survives the clock wrap
        end else if (ax < xlo || ax > xhi || ay < ylo || ay > yhi) begin
          settle_cnt = '0;
          session_on = 1'b0;
        end else begin
          mx = scale_axis(ax, xlo, xhi, cfg_shadow.orientation[1], X_TOP);
          my = scale_axis(ay, ylo, yhi, cfg_shadow.orientation[2], Y_TOP);
          if (last_ok && (px_dist(mx, last_px) > MAX_STEP_PX ||
                          px_dist(my, last_py) > MAX_STEP_PX)) begin
            settle_cnt = '0;
            session_on = 1'b0;
          end else begin
            last_px = mx;
            last_py = my;
            last_ok = 1'b1;
            if (settle_cnt < STABLE_NEEDED) begin
              settle_cnt = settle_cnt + 2'd1;
            end else begin
              if (!session_on) begin
                activity_ms = w.now_ms;
                session_on  = 1'b1;
              end
              s.pressed = 1'b1;
              s.point_x = mx;
              s.point_y = my;
            end
          end
        end
      end
      FUNC_IDLE: begin
        if (disp_mode == MODE_ACTIVE && cfg_shadow.timeout_sec != 16'd0 &&
            (w.now_ms - activity_ms) >= 32'(cfg_shadow.timeout_sec) * 32'(MS_PER_SEC)) begin
          disp_mode = MODE_SAVER;
          s.saver   = 1'b1;
        end
      end
      FUNC_BRIGHT: begin
        duty = w.bright;
        if (w.bright == 8'd0) disp_mode = MODE_SLEEP;
      end
      default: ;
    endcase
    s.mode      = disp_mode;
    s.backlight = duty;
    return s;
  endfunction

  // ---------------------------------------------------------------- drivers

  function automatic touch_word_t tw(input logic [1:0] f, input logic [31:0] t,
                                     input logic tch, input int x, y, z, b);
    touch_word_t w;
    w.func    = f;
    w.now_ms  = t;
    w.touched = tch;
    w.raw_x   = RAW_W'(x);
    w.raw_y   = RAW_W'(y);
    w.raw_z   = RAW_W'(z);
    w.bright  = 8'(b);
    return w;
  endfunction

  function automatic status_word_t st(input logic pr, input int px, py,
                                      input mode_e m, input int bl,
                                      input logic wk, sv);
    status_word_t s;
    s.pressed   = pr;
    s.point_x   = PT_W'(px);
    s.point_y   = PT_W'(py);
    s.mode      = m;
    s.backlight = 8'(bl);
    s.woke      = wk;
    s.saver     = sv;
    return s;
  endfunction

  task automatic add_row(input touch_word_t w, input logic known, input status_word_t s);
    directed_row_t r;
    r.w     = w;
    r.known = known;
    r.s     = s;
    dir_rows.push_back(r);
  endtask

  task automatic pause_input(input int n);
    @(negedge clk_i) in_valid_i <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  // offer one word, hold it until taken, then queue its expected status
  task automatic issue(input touch_word_t w, input logic known, input status_word_t s);
    status_word_t p;
    @(negedge clk_i);
    in_valid_i         <= 1'b1;
    func_i             <= w.func;
    now_ms_i           <= w.now_ms;
    touched_i          <= w.touched;
    raw_x_i            <= w.raw_x;
    raw_y_i            <= w.raw_y;
    raw_z_i            <= w.raw_z;
    brightness_value_i <= w.bright;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    p = predict_status(w);
    status_q.push_back(known ? s : p);
    n_words++;
    n_press += p.pressed;
    n_wake  += p.woke;
    n_saver += p.saver;
    burst_left--;
    if (burst_left <= 0) begin
      pause_input($urandom_range(1, 12));
      burst_left = $urandom_range(1, 30);
    end
  endtask

  task automatic drain();
    pause_input(1);
    while (status_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic cfg_write(input reg_idx_e idx, input logic [15:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    case (idx)
      REG_ORIENT:    cfg_shadow.orientation  = data[2:0];
      REG_RAW_MIN_X: cfg_shadow.raw_min_x    = data[RAW_W-1:0];
      REG_RAW_MAX_X: cfg_shadow.raw_max_x    = data[RAW_W-1:0];
      REG_RAW_MIN_Y: cfg_shadow.raw_min_y    = data[RAW_W-1:0];
      REG_RAW_MAX_Y: cfg_shadow.raw_max_y    = data[RAW_W-1:0];
      REG_PRESS_MIN: cfg_shadow.pressure_min = data[RAW_W-1:0];
      REG_TIMEOUT:   cfg_shadow.timeout_sec  = data;
      default: ;
    endcase
    @(negedge clk_i) cfg_valid_i <= 1'b0;
  endtask

  task automatic setup(input int orient, min_x, max_x, min_y, max_y, p_min, tmo);
    drain();
    cfg_write(REG_ORIENT,    16'(orient));
    cfg_write(REG_RAW_MIN_X, 16'(min_x));
    cfg_write(REG_RAW_MAX_X, 16'(max_x));
    cfg_write(REG_RAW_MIN_Y, 16'(min_y));
    cfg_write(REG_RAW_MAX_Y, 16'(max_y));
    cfg_write(REG_PRESS_MIN, 16'(p_min));
    cfg_write(REG_TIMEOUT,   16'(tmo));
    n_settings++;
  endtask

  // jittered raw reading near a gesture center, kept inside a non-empty window
  function automatic logic [RAW_W-1:0] near(input int c, lo, hi);
    int v;
    v = c + int'($urandom_range(0, 48)) - 24;
    if (lo > hi) begin
      lo = 0;
      hi = 4095;
    end
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    return RAW_W'(v);
  endfunction

  // mostly well-formed gestures, plus idle checks, backlight writes and noise
  task automatic run_random(input int count, input logic with_hold);
    touch_word_t w;
    int          kind;
    int          pmin;
    logic [31:0] adv;
    if ($urandom_range(0, 2) == 0) now_cursor = $urandom;
    pmin = int'(cfg_shadow.pressure_min);
    for (int i = 0; i < count; i++) begin
      if (with_hold && i == count / 2) hold_asks++;
      kind = $urandom_range(0, 99);
      case ($urandom_range(0, 99)) inside
        [0:69]:  adv = $urandom_range(1, 60);
        [70:89]: adv = $urandom_range(60, 400);
        [90:96]: adv = $urandom_range(1000, 70000);
        default: adv = $urandom;
      endcase
      now_cursor = now_cursor + adv;
      w.func    = FUNC_TOUCH;
      w.now_ms  = now_cursor;
      w.touched = 1'($urandom);
      w.raw_x   = RAW_W'($urandom);
      w.raw_y   = RAW_W'($urandom);
      w.raw_z   = RAW_W'($urandom);
      w.bright  = 8'($urandom);
      if (kind < 62) begin
        if (gest_left == 0) begin
          // every gesture opens with a release
          gest_left = $urandom_range(2, 10);
          gest_x    = (cfg_shadow.raw_min_x <= cfg_shadow.raw_max_x) ?
                      $urandom_range(cfg_shadow.raw_min_x, cfg_shadow.raw_max_x) :
                      $urandom_range(0, 4095);
          gest_y    = (cfg_shadow.raw_min_y <= cfg_shadow.raw_max_y) ?
                      $urandom_range(cfg_shadow.raw_min_y, cfg_shadow.raw_max_y) :
                      $urandom_range(0, 4095);
          w.touched = 1'b0;
        end else begin
          gest_left--;
          w.touched = 1'b1;
          w.raw_x   = near(gest_x, cfg_shadow.raw_min_x, cfg_shadow.raw_max_x);
          w.raw_y   = near(gest_y, cfg_shadow.raw_min_y, cfg_shadow.raw_max_y);
          if (pmin > 0 && $urandom_range(0, 9) == 0)
            w.raw_z = RAW_W'($urandom_range(0, pmin - 1));
          else
            w.raw_z = RAW_W'($urandom_range(pmin, 4095));
        end
      end else if (kind < 74) begin
        w.func = FUNC_IDLE;
      end else if (kind < 82) begin
        w.func = FUNC_BRIGHT;
        if ($urandom_range(0, 3) == 0) w.bright = 8'd0;
      end else if (kind < 86) begin
        w.func = FUNC_SPARE;
      end
      issue(w, 1'b0, '0);
    end
  endtask

  // ---------------------------------------------------------------- receiver

  initial begin
    int          pat_mode;
    int          pat_left;
    logic [31:0] pat_bits;
    pat_mode    = 0;
    pat_left    = 0;
    pat_bits    = '0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (hold_seen != hold_asks) begin
        hold_seen   = hold_asks;
        hold_left   = LONG_HOLD - 1;
        out_stall_i <= 1'b1;
      end else begin
        if (pat_left == 0) begin
          pat_mode = $urandom_range(0, 3);
          pat_left = $urandom_range(20, 120);
          pat_bits = $urandom;
        end
        pat_left--;
        case (pat_mode)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= ($urandom_range(0, 3) == 0);
          2:       out_stall_i <= pat_bits[pat_left[4:0]];
          default: out_stall_i <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- checker

  task automatic check_field(input string name, input logic [31:0] exp_v, got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      fail_cnt++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (status_q.size() == 0) begin
        $error("result word with nothing outstanding");
        fail_cnt++;
      end else begin
        want = status_q.pop_front();
        check_field("pressed", 32'(want.pressed), 32'(pressed_o));
        check_field("point_x", 32'(want.point_x), 32'(point_x_o));
        check_field("point_y", 32'(want.point_y), 32'(point_y_o));
        check_field("display_mode", 32'(want.mode), 32'(display_mode_o));
        check_field("backlight", 32'(want.backlight), 32'(backlight_o));
        check_field("woke", 32'(want.woke), 32'(woke_o));
        check_field("screensaver_entered", 32'(want.saver), 32'(screensaver_entered_o));
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    int lo_x, hi_x, lo_y, hi_y;
    rst_ni             = 1'b0;
    in_valid_i         = 1'b0;
    func_i             = FUNC_TOUCH;
    now_ms_i           = '0;
    touched_i          = 1'b0;
    raw_x_i            = '0;
    raw_y_i            = '0;
    raw_z_i            = '0;
    brightness_value_i = '0;
    cfg_valid_i        = 1'b0;
    cfg_index_i        = REG_ORIENT;
    cfg_data_i         = '0;

    cfg_shadow.orientation  = 3'd0;
    cfg_shadow.raw_min_x    = '0;
    cfg_shadow.raw_max_x    = 12'd4095;
    cfg_shadow.raw_min_y    = '0;
    cfg_shadow.raw_max_y    = 12'd4095;
    cfg_shadow.pressure_min = '0;
    cfg_shadow.timeout_sec  = 16'd30;
    disp_mode   = MODE_ACTIVE;
    duty        = FULL_BRIGHT;
    activity_ms = '0;
    quiet_until = '0;
    last_px     = '0;
    last_py     = '0;
    last_ok     = 1'b0;
    settle_cnt  = '0;
    session_on  = 1'b0;

    // reset defaults: full raw window, no pressure floor, 30 s timeout
    add_row(tw(FUNC_IDLE, 0, 0, 0, 0, 0, 0), 1,
            st(0, 0, 0, MODE_ACTIVE, 255, 0, 0));
    add_row(tw(FUNC_TOUCH, 5, 0, 0, 0, 0, 0), 1,
            st(0, 0, 0, MODE_ACTIVE, 255, 0, 0));
    add_row(tw(FUNC_TOUCH, 10, 1, 0, 0, 4095, 0), 1,
            st(0, 0, 0, MODE_ACTIVE, 255, 0, 0));
    add_row(tw(FUNC_TOUCH, 20, 1, 0, 0, 4095, 0), 1,
            st(0, 0, 0, MODE_ACTIVE, 255, 0, 0));
    // third stable read reports the press
    add_row(tw(FUNC_TOUCH, 30, 1, 0, 0, 4095, 0), 1,
            st(1, 0, 0, MODE_ACTIVE, 255, 0, 0));
    // jump to the far corner breaks stability
    add_row(tw(FUNC_TOUCH, 40, 1, 4095, 4095, 4095, 0), 1,
            st(0, 0, 0, MODE_ACTIVE, 255, 0, 0));
    add_row(tw(FUNC_SPARE, 50, 1, 4095, 4095, 4095, 255), 1,
            st(0, 0, 0, MODE_ACTIVE, 255, 0, 0));
    add_row(tw(FUNC_BRIGHT, 60, 0, 0, 0, 0, 255), 1,
            st(0, 0, 0, MODE_ACTIVE, 255, 0, 0));
    add_row(tw(FUNC_BRIGHT, 70, 0, 0, 0, 0, 0), 1,
            st(0, 0, 0, MODE_SLEEP, 0, 0, 0));
    // touch wakes from sleep, then the ignore window
    add_row(tw(FUNC_TOUCH, 1000, 1, 2048, 2048, 4095, 0), 1,
            st(0, 0, 0, MODE_ACTIVE, 255, 1, 0));
    add_row(tw(FUNC_TOUCH, 1100, 1, 2048, 2048, 4095, 0), 1,
            st(0, 0, 0, MODE_ACTIVE, 255, 0, 0));
    add_row(tw(FUNC_TOUCH, 1300, 1, 2048, 2048, 4095, 0), 0, '0);
    // timeout lands exactly on the boundary
    add_row(tw(FUNC_IDLE, 31000, 0, 0, 0, 0, 0), 1,
            st(0, 0, 0, MODE_SAVER, 255, 0, 1));
    add_row(tw(FUNC_IDLE, 31001, 0, 0, 0, 0, 0), 1,
            st(0, 0, 0, MODE_SAVER, 255, 0, 0));
    add_row(tw(FUNC_TOUCH, 32000, 1, 100, 100, 4095, 0), 1,
            st(0, 0, 0, MODE_ACTIVE, 255, 1, 0));
    add_row(tw(FUNC_BRIGHT, 32010, 0, 0, 0, 0, 128), 1,
            st(0, 0, 0, MODE_ACTIVE, 128, 0, 0));
    add_row(tw(FUNC_IDLE, 32'hFFFF_FFFF, 0, 0, 0, 0, 0), 1,
            st(0, 0, 0, MODE_SAVER, 128, 0, 1));
    // nonzero backlight keeps the screensaver
    add_row(tw(FUNC_BRIGHT, 32'hFFFF_FFFF, 0, 0, 0, 0, 77), 1,
            st(0, 0, 0, MODE_SAVER, 77, 0, 0));
    add_row(tw(FUNC_TOUCH, 32'hFFFF_FFFF, 0, 0, 0, 0, 0), 1,
            st(0, 0, 0, MODE_SAVER, 77, 0, 0));
    // wake just before the clock wraps; window ends after the wrap
    add_row(tw(FUNC_TOUCH, 32'hFFFF_FF00, 1, 4095, 0, 4095, 0), 1,
            st(0, 0, 0, MODE_ACTIVE, 255, 1, 0));
    add_row(tw(FUNC_TOUCH, 32'h0000_0010, 1, 4095, 0, 4095, 0), 1,
            st(0, 0, 0, MODE_ACTIVE, 255, 0, 0));
    add_row(tw(FUNC_TOUCH, 32'h0000_002C, 1, 4095, 0, 4095, 0), 0, '0);
    add_row(tw(FUNC_TOUCH, 32'h0000_0040, 1, 4095, 0, 4095, 0), 0, '0);
    add_row(tw(FUNC_TOUCH, 32'h0000_0050, 1, 4095, 0, 4095, 0), 1,
            st(1, 319, 0, MODE_ACTIVE, 255, 0, 0));

    repeat (8) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (dir_rows[i]) issue(dir_rows[i].w, dir_rows[i].known, dir_rows[i].s);

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: setup(0, 0, 4095, 0, 4095, 0, 30);
        1: setup(7, 0, 4095, 0, 4095, 0, 0);          // timeout disabled
        2: setup(1, 2000, 2000, 100, 3900, 2048, 1);  // x window collapsed
        3: setup(2, 3000, 1000, 0, 4095, 4095, 65535); // x window empty
        4: setup(3, 500, 3500, 800, 800, 1, 2);       // y window collapsed
        default: begin
          lo_x = $urandom_range(0, 2000);
          hi_x = $urandom_range(lo_x + 1, 4095);
          lo_y = $urandom_range(0, 2000);
          hi_y = $urandom_range(lo_y + 1, 4095);
          setup(p - 1, lo_x, hi_x, lo_y, hi_y, $urandom_range(0, 3000),
                $urandom_range(1, 5));
        end
      endcase
      run_random(PHASE_WORDS, p == 1 || p == 5);
    end

    drain();
    $display("summary: %0d words checked over %0d register settings",
             n_words, n_settings);
    $display("summary: %0d presses, %0d wakes, %0d screensaver entries",
             n_press, n_wake, n_saver);
    if (fail_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
